>>> hw/rtl/servo_pulse_slew_limiter_top_assert.svh
// Assertion macros used by the servo slew limiter checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef SERVO_PULSE_SLEW_LIMITER_TOP_ASSERT_SVH
`define SERVO_PULSE_SLEW_LIMITER_TOP_ASSERT_SVH

// same-cycle implication
`define SPSL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPSL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/spsl_pkg.sv
// Types and constants of the servo pulse slew limiter.
// No dependencies; used by the interfaces, the top level and the checker.
package spsl_pkg;

    localparam int PULSE_W = 12;
    localparam int STEP_W  = 8;
    localparam int MASK_W  = 5;
    localparam int MAXCH   = 8;

    typedef logic [PULSE_W-1:0] pulse_t;

    typedef enum logic [1:0] {
        MODE_ANGLE = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_RANGE   = 2'd1,
        ERR_CHANNEL = 2'd2,
        ERR_UNUSED  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        REG_STEP_SIZE  = 2'd0,
        REG_MIRROR_SUM = 2'd1,
        REG_MIN_PULSE  = 2'd2,
        REG_MAX_PULSE  = 2'd3
    } reg_idx_t;

    localparam logic [STEP_W-1:0]  STEP_SIZE_RST  = 8'd20;
    localparam logic [PULSE_W-1:0] MIRROR_SUM_RST = 12'd3000;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 12'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 12'd2500;

    // angle in tenths of a degree: pulse = 500 + floor(10 * angle / 9)
    localparam logic [12:0] ANGLE_OFFSET = 13'd500;
    localparam logic [11:0] ANGLE_MAX    = 12'd1800;
    localparam logic [15:0] RECIP_9      = 16'd58255;
    localparam int          RECIP_SHIFT  = 19;

    localparam pulse_t HOME_PULSE [MAXCH] = '{
        12'd1588, 12'd1778, 12'd1888, 12'd1500, 12'd700, 12'd1500, 12'd1500, 12'd1500
    };

endpackage

>>> hw/rtl/spsl_if.sv
// Valid/ready channels of the servo pulse slew limiter: commands in, pulse state out.
// Depends on spsl_pkg.
interface spsl_cmd_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [2:0]               channel;
    logic [11:0]              value;

    modport source (output valid, output mode, output channel, output value, input ready);
    modport sink   (input valid, input mode, input channel, input value, output ready);
endinterface

interface spsl_res_if;
    logic                     valid;
    logic                     ready;
    spsl_pkg::pulse_t         pulse_base;
    spsl_pkg::pulse_t         pulse_pair;
    spsl_pkg::pulse_t         pulse_mirror;
    spsl_pkg::pulse_t         pulse_wrist;
    spsl_pkg::pulse_t         pulse_turn;
    spsl_pkg::pulse_t         pulse_grip;
    logic [spsl_pkg::MASK_W-1:0] moving_mask;
    logic [1:0]               error_code;

    modport source (
        output valid, output pulse_base, output pulse_pair, output pulse_mirror,
        output pulse_wrist, output pulse_turn, output pulse_grip,
        output moving_mask, output error_code, input ready
    );
    modport sink (
        input valid, input pulse_base, input pulse_pair, input pulse_mirror,
        input pulse_wrist, input pulse_turn, input pulse_grip,
        input moving_mask, input error_code, output ready
    );
endinterface

>>> hw/rtl/servo_pulse_slew_limiter_top.sv
// Servo pulse slew limiter: per-channel current and target pulse widths with ramping.
// Depends on spsl_pkg and the channel interfaces in spsl_if.sv.
//
// Usage:
//   cmd carries one transaction per command: mode 0 sets a channel's target from an
//   angle in tenths of a degree, mode 1 from a raw pulse width, a mode 2 tick moves
//   ramping channels one step, or onto targets within two steps; mode 3 only reports.
//   res returns exactly one transaction per command: all pulse widths after the
//   update, the mirrored pulse of the pair, the moving mask and an error code.
//   The APB port writes and reads step_size, mirror_sum, min_pulse and max_pulse at
//   byte addresses 0, 4, 8 and 12; write it only while no command is in flight.
// Timing:
//   A command passes through an input register, then the per-channel compare and
//   step logic into the result register. One command is accepted every cycle
//   while res is not stalled; the channel state updates in the same cycle the result
//   register loads.
// Reset:
//   Positions and targets return to their home pulses, no channel ramps, and the
//   registers take their default values.
// Stall:
//   A result waiting on res.ready holds; one more command waits in the input
//   register, after which cmd.ready drops.
module servo_pulse_slew_limiter_top #(
    parameter int CHANNELS = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    spsl_cmd_if.sink             cmd,
    spsl_res_if.source           res
);

    // configuration registers
    logic [spsl_pkg::STEP_W-1:0] step_size_reg;
    spsl_pkg::pulse_t            mirror_sum_reg;
    spsl_pkg::pulse_t            min_pulse_reg;
    spsl_pkg::pulse_t            max_pulse_reg;
    spsl_pkg::reg_idx_t          reg_idx;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = spsl_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= spsl_pkg::STEP_SIZE_RST;
            mirror_sum_reg <= spsl_pkg::MIRROR_SUM_RST;
            min_pulse_reg  <= spsl_pkg::MIN_PULSE_RST;
            max_pulse_reg  <= spsl_pkg::MAX_PULSE_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                spsl_pkg::REG_STEP_SIZE:  step_size_reg  <= pwdata[7:0];
                spsl_pkg::REG_MIRROR_SUM: mirror_sum_reg <= pwdata[11:0];
                spsl_pkg::REG_MIN_PULSE:  min_pulse_reg  <= pwdata[11:0];
                spsl_pkg::REG_MAX_PULSE:  max_pulse_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            spsl_pkg::REG_STEP_SIZE:  prdata = {24'd0, step_size_reg};
            spsl_pkg::REG_MIRROR_SUM: prdata = {20'd0, mirror_sum_reg};
            spsl_pkg::REG_MIN_PULSE:  prdata = {20'd0, min_pulse_reg};
            spsl_pkg::REG_MAX_PULSE:  prdata = {20'd0, max_pulse_reg};
            default:                  prdata = '0;
        endcase
    end

    // input register
    logic                in_valid_reg;
    spsl_pkg::mode_t     in_mode_reg;
    logic [2:0]          in_channel_reg;
    logic [11:0]         in_value_reg;
    logic                out_valid_reg;
    logic                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_mode_reg    <= spsl_pkg::mode_t'(cmd.mode);
            in_channel_reg <= cmd.channel;
            in_value_reg   <= cmd.value;
        end
    end

    // target decode
    logic [15:0]  angle_x10;
    logic [31:0]  angle_prod;
    logic [12:0]  angle_target;
    logic [12:0]  target;
    logic         target_ok;
    logic         channel_ok;
    logic         is_cmd;
    logic         is_tick;
    logic         cmd_take;
    spsl_pkg::err_t err_next;

    assign angle_x10    = {1'b0, in_value_reg, 3'b000} + {3'b000, in_value_reg, 1'b0};
    assign angle_prod   = 32'(angle_x10) * 32'(spsl_pkg::RECIP_9);
    assign angle_target = spsl_pkg::ANGLE_OFFSET + angle_prod[spsl_pkg::RECIP_SHIFT +: 13];

    assign is_cmd     = (in_mode_reg == spsl_pkg::MODE_ANGLE)
                     || (in_mode_reg == spsl_pkg::MODE_PULSE);
    assign is_tick    = (in_mode_reg == spsl_pkg::MODE_TICK);
    assign channel_ok = {1'b0, in_channel_reg} < 4'(CHANNELS);

    always_comb
    begin
        if (in_mode_reg == spsl_pkg::MODE_ANGLE)
        begin
            target = angle_target;
        end
        else
        begin
            target = {1'b0, in_value_reg};
        end
    end

    assign target_ok = (in_mode_reg != spsl_pkg::MODE_ANGLE || in_value_reg <= spsl_pkg::ANGLE_MAX)
                    && target >= {1'b0, min_pulse_reg}
                    && target <= {1'b0, max_pulse_reg};
    assign cmd_take  = is_cmd && channel_ok && target_ok;

    always_comb
    begin
        if (!is_cmd)
        begin
            err_next = spsl_pkg::ERR_OK;
        end
        else if (!channel_ok)
        begin
            err_next = spsl_pkg::ERR_CHANNEL;
        end
        else if (!target_ok)
        begin
            err_next = spsl_pkg::ERR_RANGE;
        end
        else
        begin
            err_next = spsl_pkg::ERR_OK;
        end
    end

    // channel state
    spsl_pkg::pulse_t            pos_reg    [CHANNELS];
    spsl_pkg::pulse_t            goal_reg   [CHANNELS];
    logic [CHANNELS-1:0]         active_reg;
    spsl_pkg::pulse_t            pos_next   [CHANNELS];
    spsl_pkg::pulse_t            goal_next  [CHANNELS];
    logic [CHANNELS-1:0]         active_next;
    logic [spsl_pkg::STEP_W-1:0] step;
    logic [12:0]                 two_step;

    assign step     = (step_size_reg == '0) ? 8'd1 : step_size_reg;
    assign two_step = {4'd0, step, 1'b0};

    always_comb
    begin
        spsl_pkg::pulse_t span;
        for (int c = 0; c < CHANNELS; c++)
        begin
            pos_next[c]    = pos_reg[c];
            goal_next[c]   = goal_reg[c];
            active_next[c] = active_reg[c];
            span = (goal_reg[c] >= pos_reg[c]) ? (goal_reg[c] - pos_reg[c])
                                               : (pos_reg[c] - goal_reg[c]);
            if (is_tick && active_reg[c])
            begin
                if ({1'b0, span} < two_step)
                begin
                    pos_next[c]    = goal_reg[c];
                    active_next[c] = 1'b0;
                end
                else if (goal_reg[c] > pos_reg[c])
                begin
                    pos_next[c] = pos_reg[c] + 12'(step);
                end
                else
                begin
                    pos_next[c] = pos_reg[c] - 12'(step);
                end
            end
            else if (cmd_take && in_channel_reg == 3'(c))
            begin
                goal_next[c]   = target[11:0];
                active_next[c] = (target[11:0] != pos_reg[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                pos_reg[c]  <= spsl_pkg::HOME_PULSE[3'(c)];
                goal_reg[c] <= spsl_pkg::HOME_PULSE[3'(c)];
            end
            active_reg <= '0;
        end
        else if (advance)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                pos_reg[c]  <= pos_next[c];
                goal_reg[c] <= goal_next[c];
            end
            active_reg <= active_next;
        end
    end

    // pad to MAXCH entries, of which the first five are reported
    spsl_pkg::pulse_t pulse_all [spsl_pkg::MAXCH];
    logic [spsl_pkg::MAXCH-1:0] act_all;

    for (genvar g = 0; g < spsl_pkg::MAXCH; g++)
    begin : g_pad
        if (g < CHANNELS)
        begin : g_used
            assign pulse_all[g] = pos_next[g];
            assign act_all[g]   = active_next[g];
        end
        else
        begin : g_absent
            assign pulse_all[g] = '0;
            assign act_all[g]   = 1'b0;
        end
    end

    spsl_pkg::pulse_t mirror_next;
    assign mirror_next = (mirror_sum_reg > pulse_all[1]) ? (mirror_sum_reg - pulse_all[1]) : '0;

    // result register
    spsl_pkg::pulse_t            res_base_reg;
    spsl_pkg::pulse_t            res_pair_reg;
    spsl_pkg::pulse_t            res_mirror_reg;
    spsl_pkg::pulse_t            res_wrist_reg;
    spsl_pkg::pulse_t            res_turn_reg;
    spsl_pkg::pulse_t            res_grip_reg;
    logic [spsl_pkg::MASK_W-1:0] res_mask_reg;
    spsl_pkg::err_t              res_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_base_reg   <= pulse_all[0];
            res_pair_reg   <= pulse_all[1];
            res_mirror_reg <= mirror_next;
            res_wrist_reg  <= pulse_all[2];
            res_turn_reg   <= pulse_all[3];
            res_grip_reg   <= pulse_all[4];
            res_mask_reg   <= act_all[spsl_pkg::MASK_W-1:0];
            res_err_reg    <= err_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.pulse_base   = res_base_reg;
    assign res.pulse_pair   = res_pair_reg;
    assign res.pulse_mirror = res_mirror_reg;
    assign res.pulse_wrist  = res_wrist_reg;
    assign res.pulse_turn   = res_turn_reg;
    assign res.pulse_grip   = res_grip_reg;
    assign res.moving_mask  = res_mask_reg;
    assign res.error_code   = res_err_reg;

endmodule

>>> hw/rtl/spsl_checker.sv
// Port-level checks of the servo pulse slew limiter, bound to the top level.
// Depends on spsl_pkg and servo_pulse_slew_limiter_top_assert.svh.
`include "servo_pulse_slew_limiter_top_assert.svh"

module spsl_checker #(
    parameter int CHANNELS = 5
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input spsl_pkg::pulse_t            res_pulse_turn,
    input spsl_pkg::pulse_t            res_pulse_grip,
    input logic [spsl_pkg::MASK_W-1:0] res_moving_mask,
    input logic [1:0]                  res_error_code
);

    localparam logic [spsl_pkg::MASK_W-1:0] ABSENT_MASK =
        spsl_pkg::MASK_W'(~((1 << CHANNELS) - 1));

    `SPSL_ASSERT_IMP(a_err_legal, res_valid, res_error_code != spsl_pkg::ERR_UNUSED, "illegal error code")

    `SPSL_ASSERT_IMP(a_mask_absent, res_valid, (res_moving_mask & ABSENT_MASK) == '0, "absent channel ramping")

    `SPSL_ASSERT_IMP(a_absent_zero, res_valid && CHANNELS < 5, res_pulse_grip == '0 && (CHANNELS > 3 || res_pulse_turn == '0), "absent channel pulse not zero")

    `SPSL_ASSERT_NXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res_error_code) && $stable(res_moving_mask), "result changed under stall")

endmodule

bind servo_pulse_slew_limiter_top spsl_checker #(
    .CHANNELS(CHANNELS)
) u_spsl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_pulse_turn  (res.pulse_turn),
    .res_pulse_grip  (res.pulse_grip),
    .res_moving_mask (res.moving_mask),
    .res_error_code  (res.error_code)
);
